### hdl/srps_pkg.sv
// Package for the stepper ramp pulse sequencer: widths, request codes, motion states.
// No dependencies.
`default_nettype none
package srps_pkg;
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int SPEED_WIDTH = 16;
  localparam int FREQ_W = 28;
  localparam int QUOT_W = FREQ_W;
  localparam logic [FREQ_W-1:0] FREQ_RESET = 28'd1000000;
  localparam logic [15:0] HALF_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_LOAD_ACCEL = 2'd0,
    REQ_LOAD_DECEL = 2'd1,
    REQ_START      = 2'd2,
    REQ_COMPARE    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_ACCEL  = 3'd1,
    ST_CRUISE = 3'd2,
    ST_DECEL  = 3'd3,
    ST_STOP   = 3'd4
  } motion_t;
endpackage
`default_nettype wire

### hdl/srps_divider.sv
// Serial restoring divider producing the saturated half period freq / (2*speed).
// Depends on srps_pkg.
`default_nettype none
module srps_divider
  import srps_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [FREQ_W-1:0]      dividend,
  input  wire logic [SPEED_WIDTH-1:0] speed,
  output logic                        done,
  output logic [15:0]                 half
);
  localparam int CNT_W = $clog2(QUOT_W + 1);
  localparam int DEN_W = SPEED_WIDTH + 1;

  logic [QUOT_W-1:0] quot;
  logic [DEN_W:0]    rem;
  logic [DEN_W-1:0]  den;
  logic [CNT_W-1:0]  count;
  logic              busy;
  logic              zero_spd;
  logic [DEN_W:0]    trial;

  assign trial = {rem[DEN_W-1:0], quot[QUOT_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        quot     <= dividend;
        rem      <= '0;
        den      <= {speed, 1'b0};
        zero_spd <= (speed == '0);
        count    <= CNT_W'(QUOT_W);
      end else if (busy) begin
        // One quotient bit per cycle; quot shifts out dividend bits as it fills.
        if (trial >= {1'b0, den}) begin
          rem  <= trial - {1'b0, den};
          quot <= {quot[QUOT_W-2:0], 1'b1};
        end else begin
          rem  <= trial;
          quot <= {quot[QUOT_W-2:0], 1'b0};
        end
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (zero_spd || (quot[QUOT_W-1:16] != '0)) half = HALF_MAX;
    else half = quot[15:0];
  end
endmodule
`default_nettype wire

### hdl/stepper_ramp_pulse_sequencer_top.sv
// Top level of the stepper ramp pulse sequencer: tables in block RAM, step sequencer.
// Depends on srps_pkg and srps_divider.
`default_nettype none
// One transaction in, one result out. Loads, rejected starts and compare events that
// need no new period raise their result after passing S_READ, S_DECIDE and S_RESULT;
// starts and compare events that compute a period also wait in S_DIV for the serial
// divider (one quotient bit per cycle over the 28-bit frequency). Table reads go
// through the registered RAM read port. The next transaction is taken in the cycle after
// the result leaves. Tables hold whatever was last written; an unwritten entry reads as
// an arbitrary value.
module stepper_ramp_pulse_sequencer_top
  import srps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [27:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [9:0]  table_index,
  input  wire logic [15:0] speed_value,
  input  wire logic [10:0] accel_steps,
  input  wire logic [10:0] decel_steps,
  input  wire logic signed [31:0] move_steps,
  input  wire logic [15:0] timer_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      compare_value,
  output logic [15:0]      half_period,
  output logic             direction,
  output logic             pulse_enable,
  output logic             driver_enable,
  output logic [2:0]       motion_state,
  output logic             start_accepted,
  output logic [31:0]      total_pulses,
  output logic [30:0]      move_pulses
);
  typedef enum logic [2:0] {S_IDLE, S_READ, S_DECIDE, S_DIV, S_RESULT} seq_t;
  localparam int PTR_W = IDX_W + 1;

  seq_t seq;
  logic [FREQ_W-1:0] timer_frequency;
  logic [15:0] accel_mem [TABLE_DEPTH];
  logic [15:0] decel_mem [TABLE_DEPTH];
  logic [15:0] accel_rd, decel_rd;
  logic [IDX_W-1:0] rd_addr;

  logic [1:0]  r_req;
  logic [15:0] r_spd;
  logic [10:0] r_acc, r_dec;
  logic [31:0] r_mv;
  logic [15:0] r_cnt;

  logic        phase_bit;
  motion_t     run_state;
  logic [PTR_W-1:0] table_pointer;
  logic [30:0] step_position, target_steps, decel_point;
  logic [31:0] absolute_position;
  logic [10:0] accel_length;
  logic [15:0] cruise_speed, current_half;
  logic        dir_bit, pen_bit, den_bit;

  logic        div_start, div_done;
  logic [15:0] div_spd, div_half;

  logic        mv_neg;
  logic [31:0] mv_abs;
  logic [30:0] mag;
  logic [30:0] step_next;
  logic        accept;

  srps_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(timer_frequency),
    .speed(div_spd), .done(div_done), .half(div_half)
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = (seq != S_IDLE) || out_valid;
  assign mv_neg   = r_mv[31];
  assign mv_abs   = mv_neg ? (32'd0 - r_mv) : r_mv;
  assign mag      = mv_abs[31] ? 31'h7FFFFFFF : mv_abs[30:0];
  assign step_next = step_position + 31'd1;

  always_comb begin
    if (r_req == REQ_START) rd_addr = '0;
    else if (table_pointer >= PTR_W'(TABLE_DEPTH)) rd_addr = IDX_W'(TABLE_DEPTH - 1);
    else rd_addr = table_pointer[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept && req_type == REQ_LOAD_ACCEL) accel_mem[table_index] <= speed_value;
    if (accept && req_type == REQ_LOAD_DECEL) decel_mem[table_index] <= speed_value;
    accel_rd <= accel_mem[rd_addr];
    decel_rd <= decel_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_frequency <= FREQ_RESET;
    end else if (cfg_we) begin
      timer_frequency <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      phase_bit <= 1'b0;
      run_state <= ST_IDLE;
      table_pointer <= '0;
      step_position <= '0;
      absolute_position <= '0;
      target_steps <= '0;
      decel_point <= '0;
      accel_length <= '0;
      cruise_speed <= 16'd1;
      current_half <= '0;
      dir_bit <= 1'b0;
      pen_bit <= 1'b0;
      den_bit <= 1'b0;
      start_accepted <= 1'b0;
      compare_value <= '0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (seq)
        S_IDLE: begin
          if (accept) begin
            r_req <= req_type;
            r_spd <= speed_value;
            r_acc <= accel_steps;
            r_dec <= decel_steps;
            r_mv  <= move_steps;
            r_cnt <= timer_count;
            start_accepted <= 1'b0;
            compare_value <= '0;
            seq <= S_READ;
          end
        end
        S_READ: seq <= S_DECIDE;
        S_DECIDE: begin
          seq <= S_RESULT;
          case (r_req)
            REQ_START: begin
              if (r_acc <= 11'(TABLE_DEPTH) && r_dec <= 11'(TABLE_DEPTH) &&
                  {1'b0, mag} >= 32'(r_acc) + 32'(r_dec)) begin
                start_accepted <= 1'b1;
                target_steps <= mag;
                decel_point <= mag - 31'(r_dec);
                accel_length <= r_acc;
                cruise_speed <= r_spd;
                step_position <= '0;
                run_state <= ST_ACCEL;
                table_pointer <= PTR_W'(1);
                dir_bit <= mv_neg;
                pen_bit <= 1'b1;
                den_bit <= 1'b1;
                div_spd <= accel_rd;
                div_start <= 1'b1;
                seq <= S_DIV;
              end
            end
            REQ_COMPARE: begin
              if (pen_bit) begin
                phase_bit <= ~phase_bit;
                if (phase_bit) begin
                  // Second toggle of a step: the step completes here.
                  absolute_position <= absolute_position + 32'd1;
                  if (run_state != ST_IDLE && run_state != ST_STOP)
                    step_position <= step_next;
                  case (run_state)
                    ST_ACCEL: begin
                      div_start <= 1'b1;
                      seq <= S_DIV;
                      if (step_next >= 31'(accel_length)) begin
                        run_state <= ST_CRUISE;
                        div_spd <= cruise_speed;
                      end else begin
                        div_spd <= accel_rd;
                        if (table_pointer < PTR_W'(TABLE_DEPTH))
                          table_pointer <= table_pointer + PTR_W'(1);
                      end
                    end
                    ST_CRUISE: begin
                      div_spd <= cruise_speed;
                      div_start <= 1'b1;
                      seq <= S_DIV;
                      if (step_next >= decel_point) begin
                        table_pointer <= '0;
                        run_state <= ST_DECEL;
                      end
                    end
                    ST_DECEL: begin
                      div_spd <= decel_rd;
                      div_start <= 1'b1;
                      seq <= S_DIV;
                      if (table_pointer < PTR_W'(TABLE_DEPTH))
                        table_pointer <= table_pointer + PTR_W'(1);
                      if (step_next >= target_steps) run_state <= ST_STOP;
                    end
                    ST_STOP: begin
                      pen_bit <= 1'b0;
                      run_state <= ST_IDLE;
                    end
                    default: ;
                  endcase
                end
                if (!phase_bit || run_state == ST_IDLE || run_state == ST_STOP)
                  compare_value <= r_cnt + current_half;
              end
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            current_half <= div_half;
            if (r_req == REQ_START) compare_value <= div_half;
            else compare_value <= r_cnt + div_half;
            seq <= S_RESULT;
          end
        end
        S_RESULT: begin
          out_valid <= 1'b1;
          seq <= S_IDLE;
        end
        default: seq <= S_IDLE;
      endcase
    end
  end

  assign half_period   = current_half;
  assign direction     = dir_bit;
  assign pulse_enable  = pen_bit;
  assign driver_enable = den_bit;
  assign motion_state  = run_state;
  assign total_pulses  = absolute_position;
  assign move_pulses   = step_position;

  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    (seq != S_IDLE) |-> !out_valid || $past(out_valid))
    else $error("result raised while a transaction was still in work");
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (seq == S_DIV) |-> in_stall)
    else $error("input taken during a division");
  a_pulse_drv: assert property (@(posedge clk) disable iff (rst)
    pen_bit |-> den_bit)
    else $error("pulse channel on without driver enable");
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    table_pointer <= PTR_W'(TABLE_DEPTH))
    else $error("table pointer past the end");
endmodule
`default_nettype wire

### test/tb.sv
// Testbench for the stepper ramp pulse sequencer: table loads, starts and compare events.
// Depends on srps_pkg and stepper_ramp_pulse_sequencer_top; self-checking against
// an in-bench step sequencer model.
`default_nettype none
module tb;
  import srps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] cmp;
    logic [15:0] half;
    logic        dir;
    logic        pen;
    logic        den;
    logic [2:0]  mstate;
    logic        accepted;
    logic [31:0] total;
    logic [30:0] moved;
  } step_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [27:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = REQ_COMPARE;
  logic [9:0]  table_index = '0;
  logic [15:0] speed_value = '0;
  logic [10:0] accel_steps = '0;
  logic [10:0] decel_steps = '0;
  logic signed [31:0] move_steps = '0;
  logic [15:0] timer_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] compare_value;
  logic [15:0] half_period;
  logic        direction;
  logic        pulse_enable;
  logic        driver_enable;
  logic [2:0]  motion_state;
  logic        start_accepted;
  logic [31:0] total_pulses;
  logic [30:0] move_pulses;

  stepper_ramp_pulse_sequencer_top DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .table_index(table_index), .speed_value(speed_value),
    .accel_steps(accel_steps), .decel_steps(decel_steps),
    .move_steps(move_steps), .timer_count(timer_count),
    .out_valid(out_valid), .out_stall(out_stall), .compare_value(compare_value),
    .half_period(half_period), .direction(direction), .pulse_enable(pulse_enable),
    .driver_enable(driver_enable), .motion_state(motion_state),
    .start_accepted(start_accepted), .total_pulses(total_pulses),
    .move_pulses(move_pulses)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sequencer model state.
  logic [27:0] m_freq;
  logic [15:0] m_accel_tab [TABLE_DEPTH];
  logic [15:0] m_decel_tab [TABLE_DEPTH];
  bit          accel_written [TABLE_DEPTH];
  bit          decel_written [TABLE_DEPTH];
  logic        m_phase;
  motion_t     m_state;
  logic [10:0] m_ptr;
  logic [30:0] m_step_pos;
  logic [31:0] m_abs_pos;
  logic [30:0] m_target;
  logic [30:0] m_decel_at;
  logic [10:0] m_accel_len;
  logic [15:0] m_cruise;
  logic [15:0] m_half;
  logic        m_dir, m_pen, m_den;

  step_result_t pending_results[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_starts = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic logic [15:0] half_for(logic [15:0] spd);
    logic [63:0] q;
    if (spd == 16'd0) return HALF_MAX;
    q = 64'(m_freq) / (64'(spd) * 64'd2);
    return (q > 64'hFFFF) ? HALF_MAX : q[15:0];
  endfunction

  function automatic logic [15:0] table_read(bit use_decel, logic [10:0] idx);
    int i;
    i = (idx >= TABLE_DEPTH) ? TABLE_DEPTH - 1 : int'(idx);
    return use_decel ? m_decel_tab[i] : m_accel_tab[i];
  endfunction

  function automatic void bump_ptr();
    if (m_ptr < TABLE_DEPTH) m_ptr = m_ptr + 11'd1;
  endfunction

  function automatic void finish_step();
    m_abs_pos = m_abs_pos + 32'd1;
    if (m_state != ST_IDLE && m_state != ST_STOP) m_step_pos = m_step_pos + 31'd1;
    case (m_state)
      ST_ACCEL: begin
        if (32'(m_step_pos) >= 32'(m_accel_len)) begin
          m_state = ST_CRUISE;
          m_half = half_for(m_cruise);
        end else begin
          m_half = half_for(table_read(1'b0, m_ptr));
          bump_ptr();
        end
      end
      ST_CRUISE: begin
        m_half = half_for(m_cruise);
        if (m_step_pos >= m_decel_at) begin
          m_ptr = '0;
          m_state = ST_DECEL;
        end
      end
      ST_DECEL: begin
        m_half = half_for(table_read(1'b1, m_ptr));
        bump_ptr();
        if (m_step_pos >= m_target) m_state = ST_STOP;
      end
      ST_STOP: begin
        m_pen = 1'b0;
        m_state = ST_IDLE;
      end
      default: ;
    endcase
  endfunction

  function automatic void model_reset();
    m_freq = FREQ_RESET;
    m_phase = 0; m_state = ST_IDLE; m_ptr = '0; m_step_pos = '0; m_abs_pos = '0;
    m_target = '0; m_decel_at = '0; m_accel_len = '0; m_cruise = 16'd1; m_half = '0;
    m_dir = 0; m_pen = 0; m_den = 0;
  endfunction

  // Applies one accepted transaction to the model and queues the expected result.
  function automatic void predict_transaction(req_t req, logic [9:0] idx, logic [15:0] spd,
      logic [10:0] acc, logic [10:0] dec, logic [31:0] mv, logic [15:0] cnt);
    logic [31:0] mag;
    step_result_t r;
    r = '0;
    case (req)
      REQ_LOAD_ACCEL: begin
        m_accel_tab[idx] = spd;
        accel_written[idx] = 1;
      end
      REQ_LOAD_DECEL: begin
        m_decel_tab[idx] = spd;
        decel_written[idx] = 1;
      end
      REQ_START: begin
        mag = mv[31] ? (32'd0 - mv) : mv;
        if (mag > 32'h7FFFFFFF) mag = 32'h7FFFFFFF;
        if (acc <= TABLE_DEPTH && dec <= TABLE_DEPTH && mag >= 32'(acc) + 32'(dec)) begin
          r.accepted = 1;
          n_starts++;
          m_target = mag[30:0];
          m_decel_at = 31'(mag - 32'(dec));
          m_accel_len = acc;
          m_cruise = spd;
          m_step_pos = '0;
          m_state = ST_ACCEL;
          m_half = half_for(m_accel_tab[0]);
          m_ptr = 11'd1;
          m_dir = mv[31]; m_pen = 1; m_den = 1;
          r.cmp = m_half;
        end
      end
      default: begin
        if (m_pen) begin
          m_phase = ~m_phase;
          if (!m_phase) finish_step();
          r.cmp = cnt + m_half;
        end
      end
    endcase
    r.half = m_half; r.dir = m_dir; r.pen = m_pen; r.den = m_den;
    r.mstate = m_state; r.total = m_abs_pos; r.moved = m_step_pos;
    pending_results.push_back(r);
  endfunction

  // Number of entries written without a gap from entry 0.
  function automatic int written_prefix(bit use_decel);
    int i;
    for (i = 0; i < TABLE_DEPTH; i++)
      if (!(use_decel ? decel_written[i] : accel_written[i])) return i;
    return TABLE_DEPTH;
  endfunction

  task automatic send_transaction(req_t req, logic [9:0] idx, logic [15:0] spd,
      logic [10:0] acc, logic [10:0] dec, logic [31:0] mv, logic [15:0] cnt);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    req_type <= req; table_index <= idx; speed_value <= spd;
    accel_steps <= acc; decel_steps <= dec; move_steps <= mv; timer_count <= cnt;
    // in_stall is settled at the falling edge; low there means the next edge accepts.
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    predict_transaction(req, idx, spd, acc, dec, mv, cnt);
    n_sent++;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_frequency(logic [27:0] f);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_freq = f;
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  function automatic void check_field(string name, longint unsigned exp_v,
      longint unsigned got_v);
    if (exp_v != got_v) begin
      errors++;
      $display("%0t: mismatch in %s: expected %0d, actual %0d", $realtime, name, exp_v,
               got_v);
    end
  endfunction

  always @(negedge clk) begin
    step_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no transaction outstanding", $realtime);
      end else begin
        e = pending_results.pop_front();
        check_field("compare_value", e.cmp, compare_value);
        check_field("half_period", e.half, half_period);
        check_field("direction", e.dir, direction);
        check_field("pulse_enable", e.pen, pulse_enable);
        check_field("driver_enable", e.den, driver_enable);
        check_field("motion_state", e.mstate, motion_state);
        check_field("start_accepted", e.accepted, start_accepted);
        check_field("total_pulses", e.total, total_pulses);
        check_field("move_pulses", e.moved, move_pulses);
        n_checked++;
      end
    end
  end

  task automatic run_compares(int n);
    repeat (n) send_transaction(REQ_COMPARE, 10'($urandom), 16'($urandom), 11'($urandom),
                                11'($urandom), $urandom, 16'($urandom));
  endtask

  task automatic test_directed();
    send_transaction(REQ_LOAD_ACCEL, 10'd0, 16'd0, 11'd0, 11'd0, 32'd0, 16'd0);
    send_transaction(REQ_LOAD_ACCEL, 10'd1, 16'd1, 11'd2047, 11'd2047, 32'hFFFFFFFF, 16'hFFFF);
    send_transaction(REQ_LOAD_ACCEL, 10'd2, 16'hFFFF, 11'd0, 11'd0, 32'd0, 16'd0);
    send_transaction(REQ_LOAD_DECEL, 10'd0, 16'd7, 11'd0, 11'd0, 32'd0, 16'd0);
    send_transaction(REQ_LOAD_DECEL, 10'd1, 16'd0, 11'd0, 11'd0, 32'd0, 16'd0);
    send_transaction(REQ_LOAD_DECEL, 10'd1023, 16'hFFFF, 11'd0, 11'd0, 32'd0, 16'd0);
    // Compare event while the channel has never been enabled.
    send_transaction(REQ_COMPARE, 10'd0, 16'd0, 11'd0, 11'd0, 32'd0, 16'hFFFF);
    // A ramp length beyond the table, a ramp of the full table length, then a move shorter than its ramps.
    send_transaction(REQ_START, 10'd0, 16'd100, 11'd1025, 11'd0, 32'd5000, 16'd0);
    send_transaction(REQ_START, 10'd0, 16'd100, 11'd0, 11'd1024, 32'd5000, 16'd0);
    send_transaction(REQ_START, 10'd0, 16'd100, 11'd2, 11'd2, -32'sd3, 16'd0);
    // The most negative move saturates to the largest magnitude.
    send_transaction(REQ_START, 10'd0, 16'hFFFF, 11'd2, 11'd2, 32'h80000000, 16'd0);
    run_compares(5);
    // Restart while moving, with a zero cruise speed and zero-length ramps.
    send_transaction(REQ_START, 10'd0, 16'd0, 11'd0, 11'd0, 32'd1, 16'd0);
    run_compares(6);
    send_transaction(REQ_START, 10'd0, 16'd300, 11'd3, 11'd2, 32'd5, 16'd0);
    run_compares(14);
  endtask

  task automatic test_table_fill();
    for (int i = 0; i < 40; i++) begin
      send_transaction(REQ_LOAD_ACCEL, 10'(i), 16'($urandom_range(65535, 1)), '0, '0, '0, '0);
      send_transaction(REQ_LOAD_DECEL, 10'(i), 16'($urandom_range(65535, 1)), '0, '0, '0, '0);
    end
  endtask

  // Mostly complete moves with random content, the rest loads, refused starts and noise.
  task automatic test_random_moves(int n_items);
    int done, amax, dmax, acc, dec, len, pick;
    logic [31:0] mv;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        amax = written_prefix(0);
        dmax = written_prefix(1);
        acc = $urandom_range((amax < 12) ? amax : 12);
        dec = $urandom_range(((dmax < 12) ? dmax : 12) - 1);
        len = acc + dec + $urandom_range(8);
        mv = $urandom_range(1) ? -32'(len) : 32'(len);
        send_transaction(REQ_START, 10'($urandom), 16'($urandom), 11'(acc), 11'(dec), mv,
                         16'($urandom));
        len = 2 * (len + 1) + $urandom_range(3);
        if ($urandom_range(9) == 0) len = $urandom_range(2 * len);
        run_compares(len);
        done += len + 1;
      end else if (pick < 82) begin
        send_transaction(req_t'($urandom_range(1)), 10'($urandom),
                         ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom), 11'($urandom),
                         11'($urandom), $urandom, 16'($urandom));
        done++;
      end else if (pick < 92) begin
        // A start that can never be taken: ramps beyond the table.
        send_transaction(REQ_START, 10'($urandom), 16'($urandom),
                         11'($urandom_range(2047, TABLE_DEPTH + 1)), 11'($urandom), $urandom,
                         16'($urandom));
        done++;
      end else begin
        run_compares(3);
        done += 3;
      end
    end
  endtask

  task automatic test_pause_until_drained();
    wait_drained();
    send_transaction(REQ_START, '0, 16'd500, 11'd1, 11'd1, 32'd4, 16'd0);
    run_compares(12);
  endtask

  initial begin
    model_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 26; recv_idle_pct = 50;
    test_directed();
    test_table_fill();
    test_random_moves(130);
    write_frequency(28'd1);
    test_random_moves(40);
    test_pause_until_drained();
    send_idle_pct = 50; recv_idle_pct = 26;
    write_frequency(28'd200000000);
    test_random_moves(130);
    write_frequency(28'($urandom_range(200000000, 1)));
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_moves(130);
    write_frequency(FREQ_RESET);
    test_random_moves(40);
    wait_drained();
    $display("Checked %0d results from %0d transactions (%0d moves started),", n_checked,
             n_sent, n_starts);
    $display("over four timer frequencies and three idle patterns.");
    if (errors == 0) begin
      $display("** stepper_ramp_pulse_sequencer_top: PASSED **");
    end else begin
      $display("** stepper_ramp_pulse_sequencer_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("** stepper_ramp_pulse_sequencer_top: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

### files.f
hdl/srps_pkg.sv
hdl/srps_divider.sv
hdl/stepper_ramp_pulse_sequencer_top.sv
test/tb.sv
